// ===== rtl/htmd_pkg.sv =====
// ----------------------------------------------------------------------------
// htmd_pkg
// Shared widths, constants, register map and helpers of the heading turn
// motor drive.
// ----------------------------------------------------------------------------
package htmd_pkg;

  // Field widths
  localparam int HEAD_W  = 18;   // signed heading inputs
  localparam int NORM_W  = 16;   // heading reduced into 0..35999
  localparam int DIFF_W  = 17;   // raw signed difference of two normalized headings
  localparam int ERR_W   = 16;   // wrapped signed error
  localparam int MAG_W   = 15;   // |error|, at most 18000
  localparam int LEVEL_W = 15;   // PWM compare level fields and level registers

  // APB
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  // Angles, hundredths of a degree
  localparam int FULL_TURN    = 36000;
  localparam int HALF_TURN    = 18000;
  localparam int QUARTER_TURN = 9000;

  // Default PWM period top
  localparam int PWM_TOP_DEF  = 24999;

  // Register reset values
  localparam int TOL_RST      = 100;
  localparam int MIN_LVL_RST  = 8749;
  localparam int MAX_LVL_RST  = 12499;

  // Heading reduction: bias a sign-extended sample positive, then strip
  // whole turns. Bias is 4 turns, so a biased value stays below 8 turns.
  localparam int WIDE_W      = HEAD_W + 1;
  localparam int HEAD_OFFSET = 4 * FULL_TURN;
  localparam int WRAP_STEPS  = 7;

  typedef enum logic [2:0] {
    REG_LEFT_FORWARD  = 3'd0,
    REG_RIGHT_FORWARD = 3'd1,
    REG_DONE_TOL      = 3'd2,
    REG_MIN_LEVEL     = 3'd3,
    REG_MAX_LEVEL     = 3'd4
  } reg_idx_t;

  // Reduce any 18-bit heading into 0..35999. All compares run in parallel;
  // the highest threshold reached picks the subtraction.
  function automatic logic [NORM_W-1:0] wrap_heading(input logic signed [HEAD_W-1:0] v);
    logic [WIDE_W-1:0] x;
    logic [WIDE_W-1:0] r;
    x = {v[HEAD_W-1], v} + WIDE_W'(HEAD_OFFSET);
    r = x;
    for (int i = 1; i <= WRAP_STEPS; i++) begin
      if (x >= WIDE_W'(i * FULL_TURN)) begin
        r = x - WIDE_W'(i * FULL_TURN);
      end
    end
    return r[NORM_W-1:0];
  endfunction

endpackage

// ===== rtl/heading_turn_motor_drive.sv =====
// ----------------------------------------------------------------------------
// heading_turn_motor_drive
// Proportional heading controller driving two H-bridges in opposite
// directions from a target and a measured heading.
// ----------------------------------------------------------------------------
// Each request carries a target and a measured heading (hundredths of a
// degree, any 18-bit two's complement value). Both are reduced into
// 0..35999, the difference is wrapped into -18000..18000 and reported on
// heading_error. If |error| < done_tolerance, turn_done is set and all four
// bridge levels are 0. Otherwise the turn level is floor(|error|*PWM_TOP/9000),
// raised to min_turn_level and then lowered to max_turn_level. Each motor's
// polarity flag is applied, then the level is limited to 0.8*PWM_TOP and
// lifted to 0.22*PWM_TOP. Positive error drives the left motor forward
// (input one) and the right motor reverse (input two); otherwise the
// opposite. A zero level counts as forward.
// Throughput is one request per clock while drive_stall does not hold the
// output. The result passes two register stages: a first stage does
// heading reduction, wrap and tolerance compare, a second stage does the
// single reciprocal multiply (divide by 9000), band clamp and bridge steering
// into the output register.
// Configuration goes through the APB port at byte address 4*index and must
// only be written while the pipeline is empty.
// ----------------------------------------------------------------------------
module heading_turn_motor_drive #(
  parameter int PWM_TOP = htmd_pkg::PWM_TOP_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // APB configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [htmd_pkg::ADDR_W-1:0]           paddr,
  input  logic [htmd_pkg::DATA_W-1:0]           pwdata,
  output logic [htmd_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready,
  // heading request channel
  input  logic                                  heading_valid,
  output logic                                  heading_stall,
  input  logic signed [htmd_pkg::HEAD_W-1:0]    target_heading,
  input  logic signed [htmd_pkg::HEAD_W-1:0]    measured_heading,
  // drive result channel
  output logic                                  drive_valid,
  input  logic                                  drive_stall,
  output logic [htmd_pkg::LEVEL_W-1:0]          left_a_level,
  output logic [htmd_pkg::LEVEL_W-1:0]          left_b_level,
  output logic [htmd_pkg::LEVEL_W-1:0]          right_a_level,
  output logic [htmd_pkg::LEVEL_W-1:0]          right_b_level,
  output logic                                  turn_done,
  output logic signed [htmd_pkg::ERR_W-1:0]     heading_error
);
  import htmd_pkg::*;

  // Divide by 9000 as multiply by a rounded-up reciprocal. With a 28-bit
  // shift the error over |error| <= 18000 stays under 1/9000, so the
  // floor is exact.
  localparam int              RECIP_SHIFT = 28;
  localparam longint unsigned RECIP =
    ((longint'(PWM_TOP) << RECIP_SHIFT) + longint'(QUARTER_TURN) - 1) /
    longint'(QUARTER_TURN);
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int PROD_W    = MAG_W + RECIP_W;
  // raw level is at most 2*PWM_TOP
  localparam int RAW_W     = $clog2(2 * PWM_TOP + 1);
  localparam int LVL_W     = (RAW_W > LEVEL_W) ? RAW_W : LEVEL_W;
  localparam int CEIL_LVL  = PWM_TOP * 4 / 5;
  localparam int FLOOR_LVL = PWM_TOP * 11 / 50;

  typedef struct packed {
    logic [LEVEL_W-1:0] a;
    logic [LEVEL_W-1:0] b;
  } bridge_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic               left_forward;
  logic               right_forward;
  logic [LEVEL_W-1:0] done_tolerance;
  logic [LEVEL_W-1:0] min_turn_level;
  logic [LEVEL_W-1:0] max_turn_level;
  reg_idx_t           reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_forward   <= 1'b1;
      right_forward  <= 1'b1;
      done_tolerance <= LEVEL_W'(TOL_RST);
      min_turn_level <= LEVEL_W'(MIN_LVL_RST);
      max_turn_level <= LEVEL_W'(MAX_LVL_RST);
    end else if (cfg_write) begin
      case (reg_idx)
        REG_LEFT_FORWARD:  left_forward   <= pwdata[0];
        REG_RIGHT_FORWARD: right_forward  <= pwdata[0];
        REG_DONE_TOL:      done_tolerance <= pwdata[LEVEL_W-1:0];
        REG_MIN_LEVEL:     min_turn_level <= pwdata[LEVEL_W-1:0];
        REG_MAX_LEVEL:     max_turn_level <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LEFT_FORWARD:  prdata = DATA_W'(left_forward);
      REG_RIGHT_FORWARD: prdata = DATA_W'(right_forward);
      REG_DONE_TOL:      prdata = DATA_W'(done_tolerance);
      REG_MIN_LEVEL:     prdata = DATA_W'(min_turn_level);
      REG_MAX_LEVEL:     prdata = DATA_W'(max_turn_level);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: a two-stage pipe that only holds when the output is blocked.
  // A bubble in stage 1 is squeezed out even while the output is stalled.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic out_free;
  logic s1_free;
  logic in_take;

  assign out_free      = !drive_valid || !drive_stall;
  assign s1_free       = !s1_valid || out_free;
  assign heading_stall = !s1_free;
  assign in_take       = heading_valid && s1_free;

  // ---------------------------------------------------------------------------
  // Stage 1: reduce headings, wrap the difference, tolerance check
  // ---------------------------------------------------------------------------
  logic [NORM_W-1:0]        tgt_norm;
  logic [NORM_W-1:0]        meas_norm;
  logic signed [DIFF_W-1:0] diff_raw;
  logic signed [DIFF_W-1:0] diff_wrap;
  logic [MAG_W-1:0]         mag;

  logic signed [ERR_W-1:0]  s1_error;
  logic [MAG_W-1:0]         s1_mag;
  logic                     s1_done;
  logic                     s1_pos;

  always_comb begin
    tgt_norm  = wrap_heading(target_heading);
    meas_norm = wrap_heading(measured_heading);
    diff_raw  = signed'({1'b0, tgt_norm}) - signed'({1'b0, meas_norm});
    diff_wrap = diff_raw;
    if (diff_raw > DIFF_W'(HALF_TURN)) begin
      diff_wrap = diff_raw - DIFF_W'(FULL_TURN);
    end else if (diff_raw < -DIFF_W'(HALF_TURN)) begin
      diff_wrap = diff_raw + DIFF_W'(FULL_TURN);
    end
    if (diff_wrap[DIFF_W-1]) begin
      mag = MAG_W'(-diff_wrap);
    end else begin
      mag = MAG_W'(diff_wrap);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= heading_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_error <= diff_wrap[ERR_W-1:0];
      s1_mag   <= mag;
      s1_done  <= (mag < done_tolerance);
      s1_pos   <= !diff_wrap[DIFF_W-1] && (diff_wrap != '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: proportional level, band clamp, bridge steering
  // ---------------------------------------------------------------------------
  function automatic bridge_t steer(input logic [LVL_W-1:0] lvl,
                                    input logic reverse,
                                    input logic fwd);
    logic             neg;
    logic [LVL_W-1:0] m;
    bridge_t          br;
    neg = reverse && (lvl != '0);
    if (!fwd && (lvl != '0)) begin
      neg = !neg;
    end
    m = lvl;
    if (m > LVL_W'(CEIL_LVL)) begin
      m = LVL_W'(CEIL_LVL);
    end
    if (m < LVL_W'(FLOOR_LVL)) begin
      m = LVL_W'(FLOOR_LVL);
    end
    if (neg) begin
      br.a = '0;
      br.b = m[LEVEL_W-1:0];
    end else begin
      br.a = m[LEVEL_W-1:0];
      br.b = '0;
    end
    return br;
  endfunction

  logic [PROD_W-1:0] prod;
  logic [LVL_W-1:0]  lvl_raw;
  logic [LVL_W-1:0]  lvl_band;
  bridge_t           left_br;
  bridge_t           right_br;
  logic              s1_move;

  assign s1_move = s1_valid && out_free;

  always_comb begin
    prod    = PROD_W'(s1_mag) * PROD_W'(RECIP);
    lvl_raw = LVL_W'(prod >> RECIP_SHIFT);
    lvl_band = lvl_raw;
    if (lvl_band < LVL_W'(min_turn_level)) begin
      lvl_band = LVL_W'(min_turn_level);
    end
    if (lvl_band > LVL_W'(max_turn_level)) begin
      lvl_band = LVL_W'(max_turn_level);
    end
    left_br  = steer(lvl_band, !s1_pos, left_forward);
    right_br = steer(lvl_band, s1_pos, right_forward);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_valid <= 1'b0;
    end else if (out_free) begin
      drive_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      heading_error <= s1_error;
      turn_done     <= s1_done;
      if (s1_done) begin
        left_a_level  <= '0;
        left_b_level  <= '0;
        right_a_level <= '0;
        right_b_level <= '0;
      end else begin
        left_a_level  <= left_br.a;
        left_b_level  <= left_br.b;
        right_a_level <= right_br.a;
        right_b_level <= right_br.b;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // a finished turn never leaves a bridge energized
  assert property (@(posedge clk) disable iff (rst)
    drive_valid && turn_done |->
      left_a_level == '0 && left_b_level == '0 &&
      right_a_level == '0 && right_b_level == '0)
    else $error("done result with nonzero bridge level");

  // while turning, each bridge drives exactly one input; with both polarity
  // flags set the two motors never both run in reverse
  assert property (@(posedge clk) disable iff (rst)
    drive_valid && !turn_done |->
      ((left_a_level == '0) != (left_b_level == '0)) &&
      ((right_a_level == '0) != (right_b_level == '0)) &&
      (!(left_forward && right_forward) ||
       (left_a_level != '0) || (right_a_level != '0)))
    else $error("bridge steering inconsistent");

  // wrapped error stays within half a turn
  assert property (@(posedge clk) disable iff (rst)
    drive_valid |->
      heading_error >= -ERR_W'(HALF_TURN) && heading_error <= ERR_W'(HALF_TURN))
    else $error("heading error outside half turn");

endmodule

// ===== tb/sv/htmd_drive_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// htmd_drive_checker
// Watches the heading and drive channels and the APB port of the heading turn
// motor drive, predicts each drive result and compares it field by field.
// ----------------------------------------------------------------------------
module htmd_drive_checker #(
  parameter int PWM_TOP = htmd_pkg::PWM_TOP_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                pready,
  input  logic [htmd_pkg::ADDR_W-1:0]         paddr,
  input  logic [htmd_pkg::DATA_W-1:0]         pwdata,
  input  logic                                heading_valid,
  input  logic                                heading_stall,
  input  logic signed [htmd_pkg::HEAD_W-1:0]  target_heading,
  input  logic signed [htmd_pkg::HEAD_W-1:0]  measured_heading,
  input  logic                                drive_valid,
  input  logic                                drive_stall,
  input  logic [htmd_pkg::LEVEL_W-1:0]        left_a_level,
  input  logic [htmd_pkg::LEVEL_W-1:0]        left_b_level,
  input  logic [htmd_pkg::LEVEL_W-1:0]        right_a_level,
  input  logic [htmd_pkg::LEVEL_W-1:0]        right_b_level,
  input  logic                                turn_done,
  input  logic signed [htmd_pkg::ERR_W-1:0]   heading_error,
  output int                                  faults,
  output int                                  pending
);
  import htmd_pkg::*;

  localparam int CEIL_LEVEL  = PWM_TOP * 4 / 5;
  localparam int FLOOR_LEVEL = PWM_TOP * 11 / 50;

  typedef struct packed {
    logic [LEVEL_W-1:0]       left_a;
    logic [LEVEL_W-1:0]       left_b;
    logic [LEVEL_W-1:0]       right_a;
    logic [LEVEL_W-1:0]       right_b;
    logic                     done;
    logic signed [ERR_W-1:0]  err;
  } drive_cmd_t;

  drive_cmd_t          expected_drives[$];

  logic                cfg_left_fwd;
  logic                cfg_right_fwd;
  logic [LEVEL_W-1:0]  cfg_tol;
  logic [LEVEL_W-1:0]  cfg_min;
  logic [LEVEL_W-1:0]  cfg_max;

  initial begin
    faults  = 0;
    pending = 0;
  end

  // heading reduced into 0..35999
  function automatic int to_circle(input logic signed [HEAD_W-1:0] h);
    int r;
    r = int'(h) % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    return r;
  endfunction

  // one H-bridge: zero level counts as forward, polarity flips a nonzero level
  function automatic void steer_bridge(input int lvl, input bit backward, input bit polarity,
                                       output logic [LEVEL_W-1:0] a,
                                       output logic [LEVEL_W-1:0] b);
    bit rev;
    int mag;
    rev = backward && (lvl != 0);
    if (!polarity && lvl != 0) rev = !rev;
    mag = lvl;
    if (mag > CEIL_LEVEL)  mag = CEIL_LEVEL;
    if (mag < FLOOR_LEVEL) mag = FLOOR_LEVEL;
    if (rev) begin
      a = '0;
      b = LEVEL_W'(mag);
    end else begin
      a = LEVEL_W'(mag);
      b = '0;
    end
  endfunction

  function automatic drive_cmd_t predict_drive(input logic signed [HEAD_W-1:0] tgt,
                                               input logic signed [HEAD_W-1:0] meas);
    drive_cmd_t c;
    int diff;
    int mag;
    int lvl;
    diff = to_circle(tgt) - to_circle(meas);
    if (diff > HALF_TURN)  diff -= FULL_TURN;
    if (diff < -HALF_TURN) diff += FULL_TURN;
    mag = (diff < 0) ? -diff : diff;
    c = '0;
    c.err = ERR_W'(diff);
    if (mag < int'(cfg_tol)) begin
      c.done = 1'b1;
      return c;
    end
    lvl = mag * PWM_TOP / QUARTER_TURN;
    if (lvl < int'(cfg_min)) lvl = int'(cfg_min);
    if (lvl > int'(cfg_max)) lvl = int'(cfg_max);
    // positive error: left forward, right reverse
    steer_bridge(lvl, !(diff > 0), cfg_left_fwd, c.left_a, c.left_b);
    steer_bridge(lvl, diff > 0, cfg_right_fwd, c.right_a, c.right_b);
    return c;
  endfunction

  task automatic check_field(input string field, input integer want, input integer got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      faults++;
    end
  endtask

  always @(posedge clk) begin
    drive_cmd_t want;
    if (rst) begin
      cfg_left_fwd  = 1'b1;
      cfg_right_fwd = 1'b1;
      cfg_tol       = LEVEL_W'(TOL_RST);
      cfg_min       = LEVEL_W'(MIN_LVL_RST);
      cfg_max       = LEVEL_W'(MAX_LVL_RST);
      expected_drives.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_LEFT_FORWARD:  cfg_left_fwd  = pwdata[0];
          REG_RIGHT_FORWARD: cfg_right_fwd = pwdata[0];
          REG_DONE_TOL:      cfg_tol       = pwdata[LEVEL_W-1:0];
          REG_MIN_LEVEL:     cfg_min       = pwdata[LEVEL_W-1:0];
          REG_MAX_LEVEL:     cfg_max       = pwdata[LEVEL_W-1:0];
          default: ;
        endcase
      end
      if (drive_valid && !drive_stall) begin
        if (expected_drives.size() == 0) begin
          $error("drive result with no request outstanding");
          faults++;
        end else begin
          want = expected_drives.pop_front();
          check_field("left_a_level",  integer'(want.left_a),  integer'(left_a_level));
          check_field("left_b_level",  integer'(want.left_b),  integer'(left_b_level));
          check_field("right_a_level", integer'(want.right_a), integer'(right_a_level));
          check_field("right_b_level", integer'(want.right_b), integer'(right_b_level));
          check_field("turn_done",     integer'(want.done),    integer'(turn_done));
          check_field("heading_error", integer'(want.err),     integer'(heading_error));
        end
      end
      if (heading_valid && !heading_stall) begin
        expected_drives.push_back(predict_drive(target_heading, measured_heading));
      end
    end
    pending = expected_drives.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the heading turn motor drive.
// ----------------------------------------------------------------------------
// Heading requests go in with random gaps, drive results come out under a
// randomly stalling receiver; a separate checker predicts every result and
// compares it. The run walks through several register settings: reset
// values, the band and tolerance extremes, an inverted band (min above max)
// and random settings. Registers are only written once the pipeline has
// drained. A watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module tb;
  import htmd_pkg::*;

  localparam int RANDOM_PER_PHASE = 215;   // six phases, ~1300 requests total
  localparam int DRAIN_CYCLES     = 6;     // two-stage pipe plus margin
  localparam int LONG_HOLD        = 300;   // receiver back-pressure stretch
  localparam int LONG_HOLD_AFTER  = 100;   // requests sent before it starts
  localparam int WATCHDOG_LIMIT   = 2000;  // cycles with no transfer at all

  logic                      clk;
  logic                      rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      heading_valid;
  logic                      heading_stall;
  logic signed [HEAD_W-1:0]  target_heading;
  logic signed [HEAD_W-1:0]  measured_heading;
  logic                      drive_valid;
  logic                      drive_stall;
  logic [LEVEL_W-1:0]        left_a_level;
  logic [LEVEL_W-1:0]        left_b_level;
  logic [LEVEL_W-1:0]        right_a_level;
  logic [LEVEL_W-1:0]        right_b_level;
  logic                      turn_done;
  logic signed [ERR_W-1:0]   heading_error;

  int check_faults;
  int drives_pending;
  int requests_sent;
  int send_burst;
  int idle_cycles;

  heading_turn_motor_drive i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .heading_valid    (heading_valid),
    .heading_stall    (heading_stall),
    .target_heading   (target_heading),
    .measured_heading (measured_heading),
    .drive_valid      (drive_valid),
    .drive_stall      (drive_stall),
    .left_a_level     (left_a_level),
    .left_b_level     (left_b_level),
    .right_a_level    (right_a_level),
    .right_b_level    (right_b_level),
    .turn_done        (turn_done),
    .heading_error    (heading_error)
  );

  htmd_drive_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .heading_valid    (heading_valid),
    .heading_stall    (heading_stall),
    .target_heading   (target_heading),
    .measured_heading (measured_heading),
    .drive_valid      (drive_valid),
    .drive_stall      (drive_stall),
    .left_a_level     (left_a_level),
    .left_b_level     (left_b_level),
    .right_a_level    (right_a_level),
    .right_b_level    (right_b_level),
    .turn_done        (turn_done),
    .heading_error    (heading_error),
    .faults           (check_faults),
    .pending          (drives_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Headings that sit on the wrap points and at the ends of the field.
  function automatic logic signed [HEAD_W-1:0] corner_heading();
    case ($urandom_range(0, 9))
      0:       return HEAD_W'(0);
      1:       return HEAD_W'(1);
      2:       return HEAD_W'(-1);
      3:       return HEAD_W'(HALF_TURN);
      4:       return HEAD_W'(-HALF_TURN);
      5:       return HEAD_W'(FULL_TURN - 1);
      6:       return HEAD_W'(FULL_TURN);
      7:       return HEAD_W'(-72000);
      8:       return HEAD_W'(71999);
      default: return $urandom_range(0, 1) ? HEAD_W'(-131072) : HEAD_W'(131071);
    endcase
  endfunction

  // Mostly in-range headings; some pairs close together so the error lands
  // around the tolerance, some raw 18-bit values, some corners.
  function automatic void pick_pair(output logic signed [HEAD_W-1:0] tgt,
                                    output logic signed [HEAD_W-1:0] meas);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      tgt  = HEAD_W'(int'($urandom_range(0, 143999)) - 72000);
      meas = HEAD_W'(int'($urandom_range(0, 143999)) - 72000);
    end else if (r < 8) begin
      tgt  = HEAD_W'(int'($urandom_range(0, 143999)) - 72000);
      meas = HEAD_W'(int'(tgt) + int'($urandom_range(0, 600)) - 300);
    end else if (r < 9) begin
      tgt  = HEAD_W'($urandom());
      meas = HEAD_W'($urandom());
    end else begin
      tgt  = corner_heading();
      meas = corner_heading();
    end
  endfunction

  // Called at a falling edge; returns at a falling edge after the handshake,
  // having lowered valid only if a gap follows.
  task automatic send_heading(input int tgt, input int meas);
    int gap;
    heading_valid    <= 1'b1;
    target_heading   <= HEAD_W'(tgt);
    measured_heading <= HEAD_W'(meas);
    do @(posedge clk); while (heading_stall !== 1'b0);
    requests_sent++;
    if (send_burst > 0) begin
      send_burst--;
      gap = 0;
    end else begin
      gap = gap_len();
      send_burst = $urandom_range(0, 40);
    end
    @(negedge clk);
    if (gap > 0) begin
      heading_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic run_random(input int count);
    logic signed [HEAD_W-1:0] tgt;
    logic signed [HEAD_W-1:0] meas;
    for (int n = 0; n < count; n++) begin
      pick_pair(tgt, meas);
      send_heading(tgt, meas);
    end
    heading_valid <= 1'b0;
  endtask

  // Setup then access; psel stays up so writes can run back to back.
  task automatic write_reg(input reg_idx_t idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 4);
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic program_regs(input bit left_fwd, input bit right_fwd, input int tol,
                              input int lo, input int hi);
    write_reg(REG_LEFT_FORWARD, left_fwd);
    write_reg(REG_RIGHT_FORWARD, right_fwd);
    write_reg(REG_DONE_TOL, tol);
    write_reg(REG_MIN_LEVEL, lo);
    write_reg(REG_MAX_LEVEL, hi);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait for every predicted result, then let the pipe go quiet.
  task automatic settle();
    wait (drives_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Directed requests under reset register values.
  task automatic run_directed();
    send_heading(0, 0);                 // zero error, done
    send_heading(131071, -131072);      // field extremes
    send_heading(-131072, 131071);
    send_heading(-72000, 71999);        // wraps to +1, done
    send_heading(71999, -72000);        // wraps to -1, done
    send_heading(18000, 0);             // half turn stays positive
    send_heading(0, 18000);             // half turn stays negative
    send_heading(35999, 0);             // wraps to -1
    send_heading(100, 0);               // error equals tolerance: not done
    send_heading(99, 0);                // just inside tolerance
    send_heading(0, 100);               // negative error, left reverse
    send_heading(9000, 0);              // full scale, clipped to max level
    send_heading(0, 9000);
    send_heading(36000, 0);             // whole turn reduces to zero
    send_heading(-1, 0);
    send_heading(4000, 0);              // inside the band
    send_heading(-4000, 0);
    send_heading(27000, 0);             // wraps to -9000
    send_heading(-36000, 35999);
    heading_valid <= 1'b0;
  endtask

  // Stimulus
  initial begin
    int lo;
    int hi;
    int tol;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    heading_valid    = 1'b0;
    target_heading   = '0;
    measured_heading = '0;
    requests_sent    = 0;
    send_burst       = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset values
    run_directed();
    run_random(RANDOM_PER_PHASE);

    // zero tolerance, widest band, left polarity inverted
    settle();
    program_regs(1'b0, 1'b1, 0, 0, 24999);
    send_heading(0, 0);                 // zero level: forward, lifted to floor
    send_heading(1, 0);                 // tiny level lifted to floor
    send_heading(9000, 0);              // full scale hits the ceiling
    run_random(RANDOM_PER_PHASE);

    // widest tolerance, min above max, right polarity inverted
    settle();
    program_regs(1'b1, 1'b0, 18000, 24999, 0);
    run_random(RANDOM_PER_PHASE);

    // random settings; tolerance mostly small so turns dominate
    for (int p = 0; p < 3; p++) begin
      settle();
      lo  = $urandom_range(0, 24999);
      hi  = $urandom_range(0, 24999);
      tol = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18000) : $urandom_range(0, 1500);
      if (lo > hi) begin
        lo = lo ^ hi;
        hi = lo ^ hi;
        lo = lo ^ hi;
      end
      program_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), tol, lo, hi);
      run_random(RANDOM_PER_PHASE);
    end

    settle();
    if (check_faults == 0 && drives_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: random stalls with stall-free runs, plus one long hold-off
  // while the sender keeps pushing, so the pipe fills and backs up.
  initial begin : receiver
    int  stall_left;
    int  run_left;
    bit  hold_taken;
    drive_stall = 1'b0;
    stall_left  = 0;
    run_left    = 0;
    hold_taken  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_taken && requests_sent >= LONG_HOLD_AFTER) begin
        hold_taken = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        drive_stall <= 1'b1;
        stall_left--;
      end else begin
        drive_stall <= 1'b0;
        if (run_left > 0) begin
          run_left--;
        end else begin
          run_left   = $urandom_range(0, 40);
          stall_left = gap_len();
        end
      end
    end
  end

  // Watchdog: any transfer on either channel or the APB port resets it.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((heading_valid && !heading_stall) || (drive_valid && !drive_stall) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/htmd_pkg.sv
rtl/heading_turn_motor_drive.sv
tb/sv/htmd_drive_checker.sv
tb/sv/tb.sv
